### design/tlbpt_pkg.sv
// Shared types and fixed widths for the TLB and page table translator.
// No dependencies; the datapath, the controller and the core import this package.
`timescale 1ns / 1ps

package tlbpt_pkg;

  // Fixed field widths of the stream payloads
  localparam int unsigned VaWidth   = 16;
  localparam int unsigned PaWidth   = 16;
  localparam int unsigned UserWidth = 2;

  // Position of the flags in the result tuser
  localparam int unsigned UserHitBit   = 0;
  localparam int unsigned UserFaultBit = 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the accepted address, start the page table read
    logic clear;   // write one page table entry as not present
    logic finish;  // resolve the translation, update state, load the output
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its final entry
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

### design/tlbpt_ptab.sv
// Page table storage: one present bit and one frame number per page.
// Single write port, single registered read port. Uses no package items.
`timescale 1ns / 1ps

module tlbpt_ptab #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 9
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/tlbpt_tlb.sv
// Fully associative TLB with recency ranks and least recently used replacement.
// Parallel page compare; one update per translation. Uses no package items.
`timescale 1ns / 1ps

module tlbpt_tlb #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_W      = 8,
  parameter int unsigned FRAME_W     = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic               update_i,
  input  logic [FRAME_W-1:0] fill_frame_i,
  output logic               hit_o,
  output logic [FRAME_W-1:0] hit_frame_o
);

  localparam int unsigned IdxW  = $clog2(TLB_ENTRIES);
  localparam int unsigned RankW = IdxW;
  localparam logic [RankW-1:0] OldestRank = RankW'(TLB_ENTRIES - 1);

  logic [PAGE_W-1:0]  page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0] frame_q [TLB_ENTRIES];
  logic [RankW-1:0]   rank_q  [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_q;

  logic [TLB_ENTRIES-1:0] match;
  logic [IdxW-1:0] hit_idx, free_idx, victim_idx, slot;
  logic [RankW-1:0] slot_rank;
  logic full, age_all;

  // Compare all entries and pick the lowest matching, free and oldest index
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid_q[i] && (page_q[i] == page_i);
      if (match[i]) begin
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
      if (rank_q[i] == OldestRank) begin
        victim_idx = IdxW'(i);
      end
    end
  end

  assign hit_o       = |match;
  assign hit_frame_o = frame_q[hit_idx];
  assign full        = &valid_q;

  // Entry that becomes newest: the hit entry, a free entry or the victim
  assign slot      = hit_o ? hit_idx : (full ? victim_idx : free_idx);
  assign slot_rank = rank_q[slot];
  assign age_all   = !hit_o && !full;

  // Install the mapping on a miss
  always_ff @(posedge clk_i) begin
    if (update_i && !hit_o) begin
      page_q[slot]  <= page_i;
      frame_q[slot] <= fill_frame_i;
    end
  end

  // Valid bits and recency ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (update_i) begin
      valid_q[slot] <= 1'b1;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (IdxW'(i) == slot) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (age_all || (rank_q[i] < slot_rank))) begin
          rank_q[i] <= rank_q[i] + RankW'(1);
        end
      end
    end
  end

endmodule

### design/tlbpt_datapath.sv
// Datapath: request registers, TLB, page table, frame allocator, output register.
// Depends on tlbpt_pkg, tlbpt_tlb and tlbpt_ptab.
`timescale 1ns / 1ps

module tlbpt_datapath #(
  parameter int unsigned TLB_ENTRIES  = 16,
  parameter int unsigned PAGE_COUNT   = 256,
  parameter int unsigned OFFSET_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlbpt_pkg::cmd_t               cmd_i,
  output tlbpt_pkg::sts_t               sts_o,
  input  logic [tlbpt_pkg::VaWidth-1:0] va_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tlbpt_pkg::PaWidth-1:0] pa_o,
  output logic                          hit_o,
  output logic                          fault_o
);

  import tlbpt_pkg::*;

  localparam int unsigned PageW = $clog2(PAGE_COUNT);
  localparam int unsigned EntW  = PageW + 1;
  localparam logic [PageW-1:0] LastPage = PageW'(PAGE_COUNT - 1);

  logic [PageW-1:0]        page_in, page_q;
  logic [OFFSET_WIDTH-1:0] offset_q;
  logic [31:0]             page_wide, pa_wide;
  logic [PageW-1:0]        clr_cnt_q, clr_cnt_d;
  logic [PageW-1:0]        next_free_q, next_free_d;
  logic [EntW-1:0]         pt_rdata, pt_wdata;
  logic [PageW-1:0]        pt_waddr;
  logic                    pt_wen;
  logic                    pt_present;
  logic                    tlb_hit;
  logic [PageW-1:0]        tlb_frame, frame_sel;
  logic                    fault;
  logic                    out_valid_q;
  logic [PaWidth-1:0]      pa_q;
  logic                    hit_q, fault_q;

  // Split the address: page number reduced to the table size
  assign page_wide = 32'(va_i) >> OFFSET_WIDTH;
  assign page_in   = page_wide[PageW-1:0];

  // Hold the request for the lookup cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q   <= page_in;
      offset_q <= va_i[OFFSET_WIDTH-1:0];
    end
  end

  tlbpt_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_W     (PageW),
    .FRAME_W    (PageW)
  ) u_tlb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .page_i      (page_q),
    .update_i    (cmd_i.finish),
    .fill_frame_i(frame_sel),
    .hit_o       (tlb_hit),
    .hit_frame_o (tlb_frame)
  );

  // Resolve the frame: TLB first, then page table, else a fresh frame
  assign pt_present = pt_rdata[EntW-1];
  assign fault      = !tlb_hit && !pt_present;
  assign frame_sel  = tlb_hit ? tlb_frame : (pt_present ? pt_rdata[PageW-1:0] : next_free_q);

  // Page table write: clearing pass, or mark a faulted page present
  always_comb begin
    pt_wen   = 1'b0;
    pt_waddr = page_q;
    pt_wdata = {1'b1, next_free_q};
    if (cmd_i.clear) begin
      pt_wen   = 1'b1;
      pt_waddr = clr_cnt_q;
      pt_wdata = '0;
    end else if (cmd_i.finish && fault) begin
      pt_wen = 1'b1;
    end
  end

  tlbpt_ptab #(
    .DEPTH (PAGE_COUNT),
    .ADDR_W(PageW),
    .DATA_W(EntW)
  ) u_ptab (
    .clk_i    (clk_i),
    .wr_en_i  (pt_wen),
    .wr_addr_i(pt_waddr),
    .wr_data_i(pt_wdata),
    .rd_en_i  (cmd_i.load),
    .rd_addr_i(page_in),
    .rd_data_o(pt_rdata)
  );

  // Advance the clearing counter and the frame allocator
  assign clr_cnt_d = (clr_cnt_q == LastPage) ? '0 : clr_cnt_q + PageW'(1);
  assign next_free_d = (next_free_q == LastPage) ? '0 : next_free_q + PageW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      next_free_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_d;
      end
      if (cmd_i.finish && fault) begin
        next_free_q <= next_free_d;
      end
    end
  end

  // Physical address, kept to the output width
  assign pa_wide = (32'(frame_sel) << OFFSET_WIDTH) | 32'(offset_q);

  // Output register: load on finish, drop once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pa_q    <= pa_wide[PaWidth-1:0];
      hit_q   <= tlb_hit;
      fault_q <= fault;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == LastPage);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pa_o        = pa_q;
  assign hit_o       = hit_q;
  assign fault_o     = fault_q;

endmodule

### design/tlbpt_ctrl.sv
// Controller state machine: clearing pass, accept, lookup and completion.
// Depends on tlbpt_pkg for the command and status structs.
`timescale 1ns / 1ps

module tlbpt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tlbpt_pkg::sts_t sts_i,
  output tlbpt_pkg::cmd_t cmd_o
);

  import tlbpt_pkg::*;

  localparam logic [1:0] StClear  = 2'd0;
  localparam logic [1:0] StIdle   = 2'd1;
  localparam logic [1:0] StLookup = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StLookup;
        end
      end
      StLookup: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/tlb_page_table_translator_core.sv
// TLB and page table address translator: 16-bit virtual address in,
// 16-bit physical address with hit and fault flags out.
//
// Input channel s_axis: tdata carries the virtual address (page number in
// the upper bits, offset in the low OFFSET_WIDTH bits). Output channel
// m_axis: tdata carries the physical address, tuser the hit and fault flags.
// One result transaction is produced for every input transaction, in order.
//
// Flow: an address is accepted in the idle state and resolved in the lookup
// state, which loads the output register. The page table is a memory
// with a registered read port, read in the accept cycle; the TLB compare,
// frame choice and TLB/LRU/page table update happen in the lookup state,
// once the output register is free, and the next address is accepted only after it.
// Reset: TLB valid bits, ranks and the frame allocator clear at once; then a
// clearing pass over all PAGE_COUNT entries marks every page not present,
// during which s_axis_tready stays low. PAGE_COUNT must be a power of two.
// Stall: a finished result waits in the output register while m_axis_tready
// is low; the next input is still accepted and its lookup waits until the
// output register frees up.
`timescale 1ns / 1ps

module tlb_page_table_translator_core #(
  parameter int unsigned TLB_ENTRIES  = 16,
  parameter int unsigned PAGE_COUNT   = 256,
  parameter int unsigned OFFSET_WIDTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] virtual_address
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] phys_addr
  output logic [1:0]  m_axis_tuser    // [0] tlb_hit, [1] page_fault
);

  import tlbpt_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic hit, fault;

  tlbpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .va_i       (s_axis_tdata),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .pa_o       (m_axis_tdata),
    .hit_o      (hit),
    .fault_o    (fault)
  );

  // Pack the flags into tuser
  always_comb begin
    m_axis_tuser               = '0;
    m_axis_tuser[UserHitBit]   = hit;
    m_axis_tuser[UserFaultBit] = fault;
  end

  // A TLB hit never goes through the fault path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(hit && fault))
    else $error("result flagged both TLB hit and page fault");

  // Only one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.clear, cmd.finish}))
    else $error("controller issued more than one command");

  // A result is only completed into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> sts.out_free)
    else $error("result completed over an untaken result");

  // An accepted transaction is resolved before the next is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while a lookup is pending");

  // No input is taken during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !s_axis_tready)
    else $error("input ready during page table clearing");

endmodule

### sim/tlbpt_xlat_monitor.sv
// Translation monitor: watches both stream channels of the translator,
// predicts each result from its own TLB/LRU/page table model and compares.
// Depends on tlbpt_pkg for payload widths and the tuser flag positions.
`timescale 1ns / 1ps

module tlbpt_xlat_monitor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [tlbpt_pkg::VaWidth-1:0]   s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [tlbpt_pkg::PaWidth-1:0]   m_tdata_i,
  input  logic [tlbpt_pkg::UserWidth-1:0] m_tuser_i,
  output int unsigned                     pending_o,
  output int unsigned                     err_count_o,
  output int unsigned                     hit_count_o,
  output int unsigned                     fault_count_o,
  output int unsigned                     repl_count_o
);

  import tlbpt_pkg::*;

  localparam int unsigned TlbEntries  = 16;
  localparam int unsigned PageCount   = 256;
  localparam int unsigned OffsetWidth = 8;
  localparam int unsigned PageWidth   = VaWidth - OffsetWidth;
  localparam int unsigned MaxShown    = 40;

  typedef struct packed {
    logic [PaWidth-1:0] pa;
    logic               hit;
    logic               fault;
  } xlat_t;

  // Model state: TLB, recency ranks, page table and frame allocator
  logic [PageWidth-1:0] tlb_pg    [TlbEntries];
  logic [PageWidth-1:0] tlb_frm   [TlbEntries];
  bit                   tlb_vld   [TlbEntries];
  bit   [3:0]           tlb_rank  [TlbEntries];
  logic [PageWidth-1:0] pt_frame  [PageCount];
  bit                   pt_present[PageCount];
  bit   [PageWidth-1:0] next_frame;

  xlat_t       pending_xlat_q[$];
  int unsigned result_idx  = 0;
  int unsigned err_total   = 0;
  int unsigned hit_total   = 0;
  int unsigned fault_total = 0;
  int unsigned repl_total  = 0;

  assign err_count_o   = err_total;
  assign hit_count_o   = hit_total;
  assign fault_count_o = fault_total;
  assign repl_count_o  = repl_total;

  // Age valid entries younger than limit, make slot the newest
  function automatic void refresh_rank(input int unsigned slot, input int unsigned limit);
    int unsigned i;
    for (i = 0; i < TlbEntries; i++) begin
      if (tlb_vld[i] && i != slot && tlb_rank[i] < limit) tlb_rank[i] = tlb_rank[i] + 4'd1;
    end
    tlb_rank[slot] = 4'd0;
  endfunction

  // Translate one address and update the model state
  function automatic xlat_t predict_xlat(input logic [VaWidth-1:0] va);
    xlat_t                res;
    logic [PageWidth-1:0] pg;
    logic [PageWidth-1:0] frm;
    int                   slot;
    int unsigned          limit;
    int unsigned          i;
    pg    = va[VaWidth-1:OffsetWidth];
    res   = '0;
    slot  = -1;
    frm   = '0;
    for (i = 0; i < TlbEntries; i++) begin
      if (slot < 0 && tlb_vld[i] && tlb_pg[i] == pg) slot = i;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      hit_total++;
      frm = tlb_frm[slot];
      refresh_rank(slot, tlb_rank[slot]);
    end else begin
      // TLB miss: consult the page table, allocate a frame on a fault
      if (pt_present[pg]) begin
        frm = pt_frame[pg];
      end else begin
        res.fault = 1'b1;
        fault_total++;
        frm = next_frame;
        pt_frame[pg]   = frm;
        pt_present[pg] = 1'b1;
        next_frame     = next_frame + 1'b1;
      end
      // Install in the lowest free entry, else replace the oldest one
      limit = 256;
      for (i = 0; i < TlbEntries; i++) begin
        if (slot < 0 && !tlb_vld[i]) slot = i;
      end
      if (slot < 0) begin
        slot = 0;
        for (i = 1; i < TlbEntries; i++) begin
          if (tlb_rank[i] > tlb_rank[slot]) slot = i;
        end
        limit = tlb_rank[slot];
        repl_total++;
      end
      tlb_pg[slot]  = pg;
      tlb_frm[slot] = frm;
      tlb_vld[slot] = 1'b1;
      refresh_rank(slot, limit);
    end
    res.pa = {frm, va[OffsetWidth-1:0]};
    return res;
  endfunction

  // Print one mismatch line (the first few only) and count it
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_total++;
    if (err_total <= MaxShown) begin
      $display("monitor: result %0d %s: got %0h, want %0h", result_idx, what, got, want);
    end
  endtask

  // Compare result transactions, then predict the accepted input transaction
  always @(posedge clk_i) begin : watch
    xlat_t want;
    int unsigned i;
    if (!rst_ni) begin
      for (i = 0; i < TlbEntries; i++) begin
        tlb_vld[i]  = 1'b0;
        tlb_rank[i] = 4'd0;
      end
      for (i = 0; i < PageCount; i++) pt_present[i] = 1'b0;
      next_frame = '0;
      pending_xlat_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (pending_xlat_q.size() == 0) begin
          report_mismatch("result with no translation pending", m_tdata_i, 0);
        end else begin
          want = pending_xlat_q.pop_front();
          if (m_tdata_i !== want.pa) report_mismatch("phys_addr", m_tdata_i, want.pa);
          if (m_tuser_i[UserHitBit] !== want.hit) begin
            report_mismatch("tlb_hit", m_tuser_i[UserHitBit], want.hit);
          end
          if (m_tuser_i[UserFaultBit] !== want.fault) begin
            report_mismatch("page_fault", m_tuser_i[UserFaultBit], want.fault);
          end
        end
        result_idx++;
      end
      if (s_tvalid_i && s_tready_i) pending_xlat_q.push_back(predict_xlat(s_tdata_i));
    end
    pending_o <= pending_xlat_q.size();
  end

endmodule

### sim/tb.sv
// Top of the translator testbench: clock, reset, stimulus, output stalls,
// watchdog and verdict. Depends on tlbpt_pkg, tlbpt_xlat_monitor and the core.
`timescale 1ns / 1ps

module tb;
  import tlbpt_pkg::*;

  localparam int unsigned IdlePct    = 30;
  localparam int unsigned HoldCycles = 200;
  // Longest correct quiet stretch is the clearing pass after reset or one
  // output hold-off; allow many times that.
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 4;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [VaWidth-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [PaWidth-1:0]   m_axis_tdata;
  logic [UserWidth-1:0] m_axis_tuser;

  logic                 gaps_on       = 1'b0;
  int unsigned          hold_asked    = 0;
  int unsigned          sent_total    = 0;
  logic [7:0]           ws_base       = 8'h40;

  int unsigned pending;
  int unsigned err_total;
  int unsigned hit_total;
  int unsigned fault_total;
  int unsigned repl_total;

  always #5 clk_i = ~clk_i;

  tlb_page_table_translator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tlbpt_xlat_monitor u_xlat_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .pending_o     (pending),
    .err_count_o   (err_total),
    .hit_count_o   (hit_total),
    .fault_count_o (fault_total),
    .repl_count_o  (repl_total)
  );

  // Offer one address, with a random gap first, and hold it until accepted
  task automatic send_addr(input logic [VaWidth-1:0] va);
    while (gaps_on && $urandom_range(0, 99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= va;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_total++;
  endtask

  // Drop valid and wait until every pending translation has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly a drifting working set: small windows hit the TLB, wider ones
  // churn the LRU and hit the page table; the rest goes anywhere.
  task automatic random_burst(input int unsigned count);
    int unsigned n;
    int unsigned roll;
    logic [7:0]  page;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 39) ws_base = ws_base + 8'($urandom_range(4, 24));
      roll = $urandom_range(0, 99);
      if (roll < 55) page = ws_base + 8'($urandom_range(0, 9));
      else if (roll < 85) page = ws_base + 8'($urandom_range(0, 31));
      else page = 8'($urandom_range(0, 255));
      send_addr({page, 8'($urandom_range(0, 255))});
    end
  endtask

  // Drive the output ready: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_served != hold_asked) begin
        hold_served++;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d translations pending",
             QuietLimit, pending);
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme offsets and pages, hits after faults
    send_addr(16'h0000);
    send_addr(16'h00FF);
    send_addr(16'hFFFF);
    send_addr(16'hFF00);
    send_addr(16'h1234);
    send_addr(16'h12AB);
    // Fill the TLB up to its last free entry
    for (n = 0; n < 13; n++) send_addr({8'h20 + 8'(n), 8'(n * 19)});
    // Full TLB: replace the oldest entry, then revisit evicted pages that
    // are still present in the page table, then hit an entry in the middle
    send_addr(16'h30C3);
    send_addr(16'h0077);
    send_addr(16'hFF80);
    send_addr(16'h2500);

    gaps_on <= 1'b1;
    random_burst(600);

    // Long stretch without gaps; the receiver holds off while input keeps coming
    gaps_on    <= 1'b0;
    hold_asked <= hold_asked + 1;
    random_burst(300);

    // Pause input until everything is back
    wait_drained();

    gaps_on <= 1'b1;
    random_burst(400);
    hold_asked <= hold_asked + 1;
    random_burst(450);

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("summary: %0d addresses translated: %0d TLB hits, %0d page faults, %0d LRU replacements",
             sent_total, hit_total, fault_total, repl_total);
    $display("summary: random gaps on both channels, a gap-free stretch, two long output hold-offs");
    if (err_total == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
